// ===== rtl/core/fqa_pkg.sv =====
// Shared types and constants of the float ring queue with drain average.
// Holds the word structs, request and status codes, and controller/datapath links.
// No dependencies.
package fqa_pkg;

  localparam int PTR_W  = 5;
  localparam int RS_W   = 6;
  localparam int WORD_W = 32;
  localparam int MW     = 57;
  localparam int BE_W   = 10;
  localparam int DQ_W   = 56;

  localparam logic [2:0] REQ_ENQ   = 3'd0;
  localparam logic [2:0] REQ_DEQ   = 3'd1;
  localparam logic [2:0] REQ_ALL   = 3'd2;
  localparam logic [2:0] REQ_PEEK  = 3'd3;
  localparam logic [2:0] REQ_DRAIN = 3'd4;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DROP = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;

  localparam logic [WORD_W-1:0] NAN_WORD = 32'h7FC0_0000;
  localparam logic [RS_W-1:0]   RS_RESET = 6'd32;

  typedef struct packed {
    logic [2:0]        req_type;
    logic [WORD_W-1:0] value;
    logic [4:0]        amount;
    logic [4:0]        offset;
    logic              batch_first;
  } in_word_t;

  typedef struct packed {
    logic [WORD_W-1:0] value_out;
    logic [1:0]        status;
    logic              last;
    logic [4:0]        count_taken;
  } out_word_t;

  typedef struct packed {
    logic cfg_wr;
    logic enq;
    logic err_out;
    logic start_run;
    logic rd;
    logic emit;
    logic step;
    logic add_start;
    logic total_load;
    logic fin;
    logic div_start;
    logic rnd_div;
    logic avg_load;
    logic avg_out;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
    logic req_bad;
    logic cnt_zero;
    logic remain_last;
    logic rd_nan;
    logic rnd_done;
    logic div_busy;
    logic need_div;
  } dp_stat_t;

endpackage

// ===== rtl/core/fqa_fround.sv =====
// Normalize and round unit: turns a wide mantissa and biased exponent into a single word.
// Shifts one bit per cycle, then rounds to nearest even. Depends on fqa_pkg.
module fqa_fround (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic                         special,
  input  logic [fqa_pkg::WORD_W-1:0]   special_word,
  input  logic                         sign,
  input  logic signed [fqa_pkg::BE_W-1:0] be,
  input  logic [fqa_pkg::MW-1:0]       mant,
  output logic                         done,
  output logic [fqa_pkg::WORD_W-1:0]   result
);
  import fqa_pkg::*;

  typedef enum logic [1:0] {R_IDLE, R_NORM, R_DEN, R_RND} rstate_t;

  localparam logic signed [BE_W-1:0] E_ONE = 1;
  localparam logic signed [BE_W-1:0] E_TOP = 255;

  rstate_t                state;
  logic [MW-1:0]          m;
  logic signed [BE_W-1:0] e;
  logic                   sg;

  logic [23:0]            kept;
  logic                   g;
  logic                   stk;
  logic                   up;
  logic [24:0]            sum25;
  logic [23:0]            mant_r;
  logic signed [BE_W-1:0] e_r;
  logic [WORD_W-1:0]      packed_w;

  always_comb begin
    kept  = m[MW-1 -: 24];
    g     = m[MW-25];
    stk   = |m[MW-26:0];
    up    = g && (stk || kept[0]);
    sum25 = {1'b0, kept} + {24'd0, up};
    if (sum25[24]) begin
      mant_r = sum25[24:1];
      e_r    = e + E_ONE;
    end else begin
      mant_r = sum25[23:0];
      e_r    = e;
    end
    if (e_r >= E_TOP) begin
      packed_w = {sg, 8'hFF, 23'd0};
    end else if (!mant_r[23]) begin
      packed_w = {sg, 8'd0, mant_r[22:0]};
    end else begin
      packed_w = {sg, e_r[7:0], mant_r[22:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= R_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        R_IDLE: begin
          if (start) begin
            if (special) begin
              result <= special_word;
              done   <= 1'b1;
            end else begin
              m     <= mant;
              e     <= be;
              sg    <= sign;
              state <= R_NORM;
            end
          end
        end
        R_NORM: begin
          if (m == '0) begin
            result <= '0;
            done   <= 1'b1;
            state  <= R_IDLE;
          end else if (!m[MW-1]) begin
            m <= m << 1;
            e <= e - E_ONE;
          end else begin
            state <= R_DEN;
          end
        end
        R_DEN: begin
          if (e < E_ONE) begin
            m <= {1'b0, m[MW-1:2], m[1] | m[0]};
            e <= e + E_ONE;
          end else begin
            state <= R_RND;
          end
        end
        R_RND: begin
          result <= packed_w;
          done   <= 1'b1;
          state  <= R_IDLE;
        end
        default: state <= R_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/fqa_dpath.sv =====
// Datapath: slot memory, ring pointers, output register, adder front end and divider.
// Steps on commands from fqa_ctrl; uses fqa_fround and fqa_pkg.
module fqa_dpath #(
  parameter int MAX_SLOTS = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  fqa_pkg::in_word_t        in_data,
  input  logic [fqa_pkg::RS_W-1:0] cfg_data,
  input  fqa_pkg::dp_cmd_t         cmd,
  input  logic                     out_stall,
  output logic                     out_valid,
  output fqa_pkg::out_word_t       out_data,
  output fqa_pkg::dp_stat_t        stat
);
  import fqa_pkg::*;

  localparam int CAP = (MAX_SLOTS < 32) ? MAX_SLOTS : 32;
  localparam int AW  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

  function automatic logic [RS_W-1:0] eff(input logic [RS_W-1:0] r);
    logic [RS_W-1:0] v;
    v = r;
    if (v < RS_W'(2)) v = RS_W'(2);
    if (v > RS_W'(CAP)) v = RS_W'(CAP);
    return v;
  endfunction

  logic [RS_W-1:0]   ring_size;
  logic [PTR_W-1:0]  write_slot;
  logic [PTR_W-1:0]  bo;
  logic              batch_dropping;
  logic [PTR_W-1:0]  pos;
  logic [PTR_W-1:0]  remain;
  logic [PTR_W-1:0]  adv;
  logic [PTR_W-1:0]  taken;
  logic [WORD_W-1:0] mem [MAX_SLOTS];
  logic [WORD_W-1:0] rdata;
  logic [WORD_W-1:0] total;
  logic [PTR_W-1:0]  nvalid;
  logic [WORD_W-1:0] avg;
  logic [DQ_W-1:0]   dq;
  logic [PTR_W-1:0]  rem;
  logic [5:0]        dcnt;

  logic [RS_W-1:0]   s;
  logic [PTR_W-1:0]  cnt;
  logic [RS_W-1:0]   fcnt;
  logic [6:0]        sum7;
  logic [PTR_W-1:0]  idx;
  logic [RS_W-1:0]   bo_sum;
  logic [PTR_W-1:0]  bo_adv;
  logic [RS_W-1:0]   ws1;
  logic [PTR_W-1:0]  ws_next;
  logic [PTR_W-1:0]  len;
  logic              drop_first;
  logic              store;
  logic [PTR_W-1:0]  off_eff;
  logic              req_bad;

  logic              t_nan;
  logic              t_inf;
  logic              t_zero;
  logic              r_nan;
  logic              r_inf;

  logic              a_big;
  logic [WORD_W-1:0] big;
  logic [WORD_W-1:0] sml;
  logic [7:0]        eb;
  logic [7:0]        es;
  logic [7:0]        d;
  logic [26:0]       xs;
  logic [26:0]       sh;
  logic              stk;
  logic [27:0]       xa;
  logic [27:0]       bs;
  logic [27:0]       sum;
  logic              add_special;
  logic [WORD_W-1:0] add_word;

  logic [5:0]        dt;
  logic              dge;
  logic [PTR_W-1:0]  rnext;
  logic [7:0]        e_tot;

  logic              r_start;
  logic              r_special;
  logic [WORD_W-1:0] r_word;
  logic              r_sign;
  logic signed [BE_W-1:0] r_be;
  logic [MW-1:0]     r_mant;
  logic              r_done;
  logic [WORD_W-1:0] r_result;

  always_comb begin
    s = eff(ring_size);
    if (write_slot > bo) begin
      cnt = write_slot - bo - PTR_W'(1);
    end else begin
      cnt = PTR_W'(s + {1'b0, write_slot} - {1'b0, bo} - RS_W'(1));
    end
    fcnt = s - RS_W'(1) - {1'b0, cnt};

    sum7 = {2'b00, bo} + 7'd1 + {2'b00, pos};
    if (sum7 >= {1'b0, s}) begin
      idx = PTR_W'(sum7 - {1'b0, s});
    end else begin
      idx = sum7[PTR_W-1:0];
    end

    bo_sum = {1'b0, bo} + {1'b0, adv};
    if (bo_sum >= s) begin
      bo_adv = PTR_W'(bo_sum - s);
    end else begin
      bo_adv = bo_sum[PTR_W-1:0];
    end

    ws1 = {1'b0, write_slot} + RS_W'(1);
    ws_next = (ws1 == s) ? '0 : ws1[PTR_W-1:0];

    len        = (in_data.amount == '0) ? PTR_W'(1) : in_data.amount;
    drop_first = {1'b0, len} > fcnt;
    if (in_data.batch_first) begin
      store = !drop_first;
    end else begin
      store = !batch_dropping && (fcnt != '0);
    end

    off_eff = (in_data.req_type == REQ_PEEK) ? in_data.offset : '0;
    case (in_data.req_type)
      REQ_DEQ, REQ_PEEK:
        req_bad = (in_data.amount == '0) ||
                  (({1'b0, in_data.amount} + {1'b0, off_eff}) > {1'b0, cnt});
      REQ_ALL: req_bad = (cnt == '0);
      default: req_bad = 1'b0;
    endcase
  end

  always_comb begin
    t_nan  = (&total[30:23]) && (|total[22:0]);
    t_inf  = (&total[30:23]) && !(|total[22:0]);
    t_zero = (total[30:0] == '0);
    r_nan  = (&rdata[30:23]) && (|rdata[22:0]);
    r_inf  = (&rdata[30:23]) && !(|rdata[22:0]);

    add_special = t_nan || t_inf || r_inf;
    if (t_nan || (t_inf && r_inf && (total[31] != rdata[31]))) begin
      add_word = NAN_WORD;
    end else if (t_inf) begin
      add_word = total;
    end else begin
      add_word = rdata;
    end

    a_big = total[30:0] >= rdata[30:0];
    big   = a_big ? total : rdata;
    sml   = a_big ? rdata : total;
    eb    = (big[30:23] == '0) ? 8'd1 : big[30:23];
    es    = (sml[30:23] == '0) ? 8'd1 : sml[30:23];
    d     = eb - es;
    xs    = {(sml[30:23] != '0), sml[22:0], 3'b000};
    if (d >= 8'd27) begin
      sh  = '0;
      stk = |xs;
    end else begin
      sh  = xs >> d;
      stk = |(xs & ~(27'h7FF_FFFF << d));
    end
    xa = {1'b0, (big[30:23] != '0), big[22:0], 3'b000};
    bs = {1'b0, sh[26:1], sh[0] | stk};
    if (big[31] == sml[31]) begin
      sum = xa + bs;
    end else begin
      sum = xa - bs;
    end

    dt    = {rem, dq[DQ_W-1]};
    dge   = dt >= {1'b0, nvalid};
    rnext = dge ? PTR_W'(dt - {1'b0, nvalid}) : dt[PTR_W-1:0];
    e_tot = (total[30:23] == '0) ? 8'd1 : total[30:23];

    r_start = cmd.add_start || cmd.rnd_div;
    if (cmd.rnd_div) begin
      r_special = 1'b0;
      r_word    = total;
      r_sign    = total[31];
      r_be      = $signed({{(BE_W-8){1'b0}}, e_tot});
      r_mant    = {dq, (rem != '0)};
    end else begin
      r_special = add_special;
      r_word    = add_word;
      r_sign    = big[31];
      r_be      = $signed({{(BE_W-8){1'b0}}, eb}) + $signed(BE_W'(1));
      r_mant    = {sum, {(MW-28){1'b0}}};
    end
  end

  fqa_fround u_fqa_fround (
    .clk          (clk),
    .rst          (rst),
    .start        (r_start),
    .special      (r_special),
    .special_word (r_word),
    .sign         (r_sign),
    .be           (r_be),
    .mant         (r_mant),
    .done         (r_done),
    .result       (r_result)
  );

  always_ff @(posedge clk) begin
    if (cmd.enq && store) begin
      mem[AW'(write_slot)] <= in_data.value;
    end
    if (cmd.rd) begin
      rdata <= mem[AW'(idx)];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_size      <= RS_RESET;
      write_slot     <= '0;
      bo             <= PTR_W'(eff(RS_RESET) - RS_W'(1));
      batch_dropping <= 1'b0;
      out_valid      <= 1'b0;
      dcnt           <= '0;
    end else begin
      if (cmd.enq || cmd.err_out || cmd.emit || cmd.avg_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (cmd.cfg_wr) begin
        ring_size      <= cfg_data;
        write_slot     <= '0;
        bo             <= PTR_W'(eff(cfg_data) - RS_W'(1));
        batch_dropping <= 1'b0;
      end
      if (cmd.enq) begin
        if (in_data.batch_first) begin
          batch_dropping <= drop_first;
        end
        if (store) begin
          write_slot <= ws_next;
        end
        out_data  <= '{value_out: '0, status: store ? ST_OK : ST_DROP,
                       last: 1'b1, count_taken: '0};
      end
      if (cmd.err_out) begin
        out_data  <= '{value_out: '0, status: ST_BAD, last: 1'b1, count_taken: '0};
      end
      if (cmd.emit) begin
        out_data  <= '{value_out: rdata, status: ST_OK,
                       last: (remain == PTR_W'(1)), count_taken: taken};
        if (remain == PTR_W'(1)) begin
          bo <= bo_adv;
        end
      end
      if (cmd.avg_out) begin
        out_data  <= '{value_out: avg, status: ST_OK, last: 1'b1, count_taken: taken};
        bo        <= bo_adv;
      end
      if (cmd.div_start) begin
        dcnt <= 6'(DQ_W);
      end else if (dcnt != '0) begin
        dcnt <= dcnt - 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_run) begin
      pos    <= off_eff;
      remain <= (in_data.req_type == REQ_DEQ || in_data.req_type == REQ_PEEK) ?
                in_data.amount : cnt;
      if (in_data.req_type == REQ_DEQ) begin
        adv <= in_data.amount;
      end else if (in_data.req_type == REQ_PEEK) begin
        adv <= '0;
      end else begin
        adv <= cnt;
      end
      taken  <= (in_data.req_type == REQ_ALL || in_data.req_type == REQ_DRAIN) ? cnt : '0;
      total  <= '0;
      nvalid <= '0;
    end
    if (cmd.emit || cmd.step) begin
      pos    <= pos + PTR_W'(1);
      remain <= remain - PTR_W'(1);
    end
    if (cmd.total_load) begin
      total  <= r_result;
      nvalid <= nvalid + PTR_W'(1);
    end
    if (cmd.fin) begin
      avg <= (t_nan || t_zero || nvalid == '0) ? NAN_WORD : total;
    end
    if (cmd.avg_load) begin
      avg <= r_result;
    end
    if (cmd.div_start) begin
      dq  <= {(total[30:23] != '0), total[22:0], 32'd0};
      rem <= '0;
    end else if (dcnt != '0) begin
      dq  <= {dq[DQ_W-2:0], dge};
      rem <= rnext;
    end
  end

  assign stat = '{
    out_free:    !out_valid || !out_stall,
    req_bad:     req_bad,
    cnt_zero:    (cnt == '0),
    remain_last: (remain == PTR_W'(1)),
    rd_nan:      r_nan,
    rnd_done:    r_done,
    div_busy:    (dcnt != '0),
    need_div:    !(t_nan || t_inf || t_zero || nvalid == '0)
  };

endmodule

// ===== rtl/core/fqa_ctrl.sv =====
// Controller: sequences requests over the datapath by command and status.
// Owns the input stall and configuration ready. Depends on fqa_pkg.
module fqa_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [2:0]        req_type,
  input  logic              cfg_valid,
  input  fqa_pkg::dp_stat_t stat,
  output logic              in_stall,
  output logic              cfg_ready,
  output fqa_pkg::dp_cmd_t  cmd
);
  import fqa_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_EMIT, S_DRD, S_DCHK, S_DADD, S_FIN, S_DIV, S_DRND, S_DOUT
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign in_stall  = (state != S_IDLE) || !stat.out_free || cfg_valid;
  assign cfg_ready = (state == S_IDLE);
  assign accept    = in_valid && !in_stall;

  always_comb begin
    cmd        = '0;
    state_next = state;
    cmd.cfg_wr = cfg_valid && cfg_ready;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (req_type)
            REQ_ENQ: cmd.enq = 1'b1;
            REQ_DEQ, REQ_ALL, REQ_PEEK: begin
              if (stat.req_bad) begin
                cmd.err_out = 1'b1;
              end else begin
                cmd.start_run = 1'b1;
                state_next    = S_RD;
              end
            end
            REQ_DRAIN: begin
              cmd.start_run = 1'b1;
              state_next    = stat.cnt_zero ? S_FIN : S_DRD;
            end
            default: ;
          endcase
        end
      end
      S_RD: begin
        cmd.rd     = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = stat.remain_last ? S_IDLE : S_RD;
        end
      end
      S_DRD: begin
        cmd.rd     = 1'b1;
        state_next = S_DCHK;
      end
      S_DCHK: begin
        if (stat.rd_nan) begin
          cmd.step   = 1'b1;
          state_next = stat.remain_last ? S_FIN : S_DRD;
        end else begin
          cmd.add_start = 1'b1;
          state_next    = S_DADD;
        end
      end
      S_DADD: begin
        if (stat.rnd_done) begin
          cmd.total_load = 1'b1;
          cmd.step       = 1'b1;
          state_next     = stat.remain_last ? S_FIN : S_DRD;
        end
      end
      S_FIN: begin
        cmd.fin = 1'b1;
        if (stat.need_div) begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end else begin
          state_next = S_DOUT;
        end
      end
      S_DIV: begin
        if (!stat.div_busy) begin
          cmd.rnd_div = 1'b1;
          state_next  = S_DRND;
        end
      end
      S_DRND: begin
        if (stat.rnd_done) begin
          cmd.avg_load = 1'b1;
          state_next   = S_DOUT;
        end
      end
      S_DOUT: begin
        if (stat.out_free) begin
          cmd.avg_out = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/core/float_ring_queue_with_drain_average.sv =====
// Top level of the float ring queue with drain average.
// Joins fqa_ctrl and fqa_dpath; depends on fqa_pkg.
//
// Input words (valid/stall) carry one request: enqueue, dequeue count, dequeue all,
// peek or drain average. Result words leave on the output channel (valid/stall),
// the final word of a request marked by last. The configuration channel
// (valid/ready) writes ring_size and empties the queue; it is ready when no
// request is in progress.
// Enqueue: one word per cycle while the output is free, result in the output register
// the next cycle. Dequeue and peek: per result word a slot memory read, then the
// output register. Drain: stored entries are read, NaN entries skipped and the rest
// summed through the normalize/round unit; if the sum is finite and nonzero, a
// bit-serial divide by the number summed and a rounding pass form the single result word.
// A new request is taken only once the previous one has finished and the output
// register is empty or being taken. A stalled result holds its word.
// Reset empties the queue, sets ring_size to 32 and clears the output; the slot
// memory needs no clearing pass, only stored entries are ever read.
module float_ring_queue_with_drain_average #(
  parameter int MAX_SLOTS = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  fqa_pkg::in_word_t        in_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output fqa_pkg::out_word_t       out_data,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [fqa_pkg::RS_W-1:0] cfg_data
);
  import fqa_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  fqa_ctrl u_fqa_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .req_type  (in_data.req_type),
    .cfg_valid (cfg_valid),
    .stat      (stat),
    .in_stall  (in_stall),
    .cfg_ready (cfg_ready),
    .cmd       (cmd)
  );

  fqa_dpath #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_fqa_dpath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .stat      (stat)
  );

endmodule

// ===== rtl/core/fqa_checker.sv =====
// Port-level checks of the float ring queue with drain average.
// Bound to the top level; depends on fqa_pkg.
module fqa_checker (
  input logic                     clk,
  input logic                     rst,
  input logic                     in_valid,
  input logic                     in_stall,
  input fqa_pkg::in_word_t        in_data,
  input logic                     out_valid,
  input logic                     out_stall,
  input fqa_pkg::out_word_t       out_data
);
  import fqa_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(out_data))
    else $error("result word changed while stalled");

  a_rst_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  a_enq_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && in_data.req_type == REQ_ENQ |=>
      out_valid && out_data.last && out_data.count_taken == '0)
    else $error("enqueue result missing");

  a_drop_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == ST_DROP |->
      out_data.value_out == '0 && out_data.last)
    else $error("malformed drop result");

endmodule

bind float_ring_queue_with_drain_average fqa_checker u_fqa_checker (.*);
